### hdl/smps_pkg.sv
// ----------------------------------------------------------------------------
// smps_pkg
// Shared types, register indexes and reset values of the short marker pair
// suppressor.
// ----------------------------------------------------------------------------
package smps_pkg;

    localparam int unsigned RESERVE_DEPTH_DEF = 16;
    localparam int unsigned WORD_W            = 64;
    localparam int unsigned CFG_ADDR_W        = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_DURATION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_END_MARKER   = 2'd2;

    // Reset values: one second in 32.32, default start and end ids
    localparam logic [WORD_W-1:0] MIN_DURATION_RST = 64'h0000_0001_0000_0000;
    localparam logic [WORD_W-1:0] START_MARKER_RST = 64'd33024;
    localparam logic [WORD_W-1:0] END_MARKER_RST   = 64'd33025;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t id;
        word_t date;
        word_t length;
    } event_t;

    typedef enum logic {
        CMD_EMIT  = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_kind_t;

    // One unit of work for the back end: emit one event, or flush the reserve
    typedef struct packed {
        cmd_kind_t kind;
        logic      last;
        logic      ovf;
        logic      suppress;
        event_t    ev;
    } cmd_t;

    // Reserve write from the front end
    typedef struct packed {
        logic   en;
        event_t ev;
    } res_wr_t;

    // Status from the back end to the front end
    typedef struct packed {
        logic flush_done;
        logic idle;
    } back_stat_t;

endpackage

### hdl/smps_queue.sv
// ----------------------------------------------------------------------------
// smps_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module smps_queue #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### hdl/smps_front.sv
// ----------------------------------------------------------------------------
// smps_front
// Accepts event markers, tracks the hold window and the reserve fill level,
// writes held events and queues emit and flush commands.
// ----------------------------------------------------------------------------
module smps_front #(
    parameter int unsigned RESERVE_DEPTH = smps_pkg::RESERVE_DEPTH_DEF,
    parameter int unsigned CW            = $clog2(RESERVE_DEPTH + 1),
    parameter int unsigned AW            = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  smps_pkg::event_t    s_ev,
    input  smps_pkg::word_t     min_duration,
    input  smps_pkg::word_t     start_marker,
    input  smps_pkg::word_t     end_marker,
    output logic                q_valid,
    input  logic                q_ready,
    output smps_pkg::cmd_t      q_cmd,
    output logic [CW-1:0]       q_count,
    output smps_pkg::res_wr_t   wr,
    output logic [AW-1:0]       wr_addr,
    input  smps_pkg::back_stat_t back_stat,
    output logic [CW-1:0]       held_count,
    output logic                flush_pending
);
    import smps_pkg::*;

    typedef enum logic [4:0] {
        F_IDLE     = 5'b00001,
        F_WINDOW   = 5'b00010,
        F_CLASSIFY = 5'b00100,
        F_PUSH_A   = 5'b01000,
        F_PUSH_B   = 5'b10000
    } fstate_t;

    fstate_t       state_reg, state_next;
    event_t        ev_reg;
    logic          is_start_reg, is_end_reg;
    word_t         window_start_reg, window_start_next;
    logic          skip_reg, skip_next;
    logic [CW-1:0] held_count_reg, held_count_next;
    logic          pending_reg, pending_next;
    logic          do_emit_reg, do_emit_next;
    logic          do_flush_reg, do_flush_next;
    logic          flush_first_reg, flush_first_next;
    logic          suppress_reg, suppress_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] flush_cnt_reg, flush_cnt_next;

    logic          markers_eq;
    logic [WORD_W:0] limit;
    logic          in_window, closes, full;
    logic          a_valid, b_valid, a_is_flush, cur_is_flush;
    logic          accept;

    assign markers_eq = (start_marker == end_marker);
    assign limit      = {1'b0, window_start_reg} + {1'b0, min_duration};
    assign in_window  = (window_start_reg != '0) &&
                        (limit[WORD_W] || (ev_reg.date <= limit[WORD_W-1:0]));
    assign closes     = is_end_reg && (!markers_eq || (ev_reg.date != window_start_reg));
    assign full       = (held_count_reg == CW'(RESERVE_DEPTH));

    // Order of the two commands: flush before emit when the event is outside
    assign a_is_flush = flush_first_reg;
    assign a_valid    = flush_first_reg ? do_flush_reg : do_emit_reg;
    assign b_valid    = flush_first_reg ? do_emit_reg : do_flush_reg;
    assign cur_is_flush = (state_reg == F_PUSH_A) ? a_is_flush : !a_is_flush;

    assign s_tready      = (state_reg == F_IDLE) && !pending_reg;
    assign accept        = s_tvalid && s_tready;
    assign held_count    = held_count_reg;
    assign flush_pending = pending_reg;
    assign wr_addr       = held_count_reg[AW-1:0];
    assign q_count       = flush_cnt_reg;

    always_comb begin
        q_cmd.kind     = cur_is_flush ? CMD_FLUSH : CMD_EMIT;
        q_cmd.last     = (state_reg == F_PUSH_B) || !b_valid;
        q_cmd.ovf      = cur_is_flush ? 1'b0 : ovf_reg;
        q_cmd.suppress = suppress_reg;
        q_cmd.ev       = ev_reg;
    end

    always_comb begin
        state_next        = state_reg;
        window_start_next = window_start_reg;
        skip_next         = skip_reg;
        held_count_next   = held_count_reg;
        do_emit_next      = do_emit_reg;
        do_flush_next     = do_flush_reg;
        flush_first_next  = flush_first_reg;
        suppress_next     = suppress_reg;
        ovf_next          = ovf_reg;
        flush_cnt_next    = flush_cnt_reg;
        wr.en             = 1'b0;
        wr.ev             = ev_reg;
        q_valid           = 1'b0;
        pending_next      = pending_reg && !back_stat.flush_done;

        case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    state_next = F_WINDOW;
                end
            end
            F_WINDOW: begin
                if (is_start_reg && !skip_reg) begin
                    window_start_next = ev_reg.date;
                end
                if (is_start_reg && markers_eq) begin
                    skip_next = !skip_reg;
                end
                state_next = F_CLASSIFY;
            end
            F_CLASSIFY: begin
                state_next = F_PUSH_A;
                if (in_window) begin
                    flush_first_next = 1'b0;
                    suppress_next    = 1'b1;
                    ovf_next         = full;
                    do_emit_next     = full;
                    do_flush_next    = closes;
                    flush_cnt_next   = full ? CW'(RESERVE_DEPTH) : CW'(held_count_reg + 1'b1);
                    if (!full) begin
                        wr.en           = 1'b1;
                        held_count_next = CW'(held_count_reg + 1'b1);
                    end
                    if (closes) begin
                        // Close the window; the reserve drains in the back end
                        window_start_next = '0;
                        held_count_next   = '0;
                    end
                end else begin
                    flush_first_next = 1'b1;
                    suppress_next    = 1'b0;
                    ovf_next         = 1'b0;
                    do_emit_next     = 1'b1;
                    do_flush_next    = (held_count_reg != '0);
                    flush_cnt_next   = held_count_reg;
                    held_count_next  = '0;
                end
            end
            F_PUSH_A: begin
                if (!a_valid) begin
                    state_next = F_PUSH_B;
                end else begin
                    q_valid = 1'b1;
                    if (q_ready) begin
                        state_next = F_PUSH_B;
                        if (a_is_flush) begin
                            pending_next = 1'b1;
                        end
                    end
                end
            end
            F_PUSH_B: begin
                if (!b_valid) begin
                    state_next = F_IDLE;
                end else begin
                    q_valid = 1'b1;
                    if (q_ready) begin
                        state_next = F_IDLE;
                        if (!a_is_flush) begin
                            pending_next = 1'b1;
                        end
                    end
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= F_IDLE;
            window_start_reg <= '0;
            skip_reg         <= 1'b0;
            held_count_reg   <= '0;
            pending_reg      <= 1'b0;
            do_emit_reg      <= 1'b0;
            do_flush_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            window_start_reg <= window_start_next;
            skip_reg         <= skip_next;
            held_count_reg   <= held_count_next;
            pending_reg      <= pending_next;
            do_emit_reg      <= do_emit_next;
            do_flush_reg     <= do_flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        flush_first_reg <= flush_first_next;
        suppress_reg    <= suppress_next;
        ovf_reg         <= ovf_next;
        flush_cnt_reg   <= flush_cnt_next;
        if (accept) begin
            ev_reg       <= s_ev;
            is_start_reg <= (s_ev.id == start_marker);
            is_end_reg   <= (s_ev.id == end_marker);
        end
    end

endmodule

### hdl/smps_back.sv
// ----------------------------------------------------------------------------
// smps_back
// Holds the event reserve, executes emit and flush commands and drives the
// registered result stage.
// ----------------------------------------------------------------------------
module smps_back #(
    parameter int unsigned RESERVE_DEPTH = smps_pkg::RESERVE_DEPTH_DEF,
    parameter int unsigned CW            = $clog2(RESERVE_DEPTH + 1),
    parameter int unsigned AW            = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  smps_pkg::cmd_t       q_cmd,
    input  logic [CW-1:0]        q_count,
    input  smps_pkg::res_wr_t    wr,
    input  logic [AW-1:0]        wr_addr,
    input  smps_pkg::word_t      start_marker,
    input  smps_pkg::word_t      end_marker,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output smps_pkg::event_t     m_ev,
    output logic                 m_tlast,
    output logic                 m_overflow,
    output smps_pkg::back_stat_t back_stat
);
    import smps_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_EMIT = 4'b0010,
        B_READ = 4'b0100,
        B_SEND = 4'b1000
    } bstate_t;

    event_t        res_mem [RESERVE_DEPTH];
    event_t        rd_reg;

    bstate_t       state_reg, state_next;
    cmd_t          cmd_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg, idx_next;
    logic          done_reg, done_next;
    logic          m_valid_reg, m_valid_next;
    event_t        m_ev_reg, m_ev_next;
    logic          m_last_reg, m_last_next;
    logic          m_ovf_reg, m_ovf_next;

    logic          out_free, pop, last_entry, hit;
    logic [CW-1:0] idx_plus;

    assign out_free   = !m_valid_reg || m_tready;
    assign q_ready    = (state_reg == B_IDLE);
    assign pop        = q_valid && q_ready;
    assign idx_plus   = CW'(idx_reg + 1'b1);
    assign last_entry = (idx_plus == cnt_reg);
    assign hit        = (rd_reg.id == start_marker) || (rd_reg.id == end_marker);

    assign m_tvalid   = m_valid_reg;
    assign m_ev       = m_ev_reg;
    assign m_tlast    = m_last_reg;
    assign m_overflow = m_ovf_reg;

    assign back_stat.flush_done = done_reg;
    assign back_stat.idle       = (state_reg == B_IDLE);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        done_next    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        m_ev_next    = m_ev_reg;
        m_last_next  = m_last_reg;
        m_ovf_next   = m_ovf_reg;

        case (state_reg)
            B_IDLE: begin
                if (pop) begin
                    idx_next   = '0;
                    state_next = (q_cmd.kind == CMD_FLUSH) ? B_READ : B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ev_next    = cmd_reg.ev;
                    m_last_next  = cmd_reg.last;
                    m_ovf_next   = cmd_reg.ovf;
                    state_next   = B_IDLE;
                end
            end
            B_READ: begin
                state_next = B_SEND;
            end
            B_SEND: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ev_next    = rd_reg;
                    if (cmd_reg.suppress && hit) begin
                        m_ev_next.id = '0;
                    end
                    m_last_next = cmd_reg.last && last_entry;
                    m_ovf_next  = 1'b0;
                    if (last_entry) begin
                        done_next  = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_plus;
                        state_next = B_READ;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        m_ev_reg   <= m_ev_next;
        m_last_reg <= m_last_next;
        m_ovf_reg  <= m_ovf_next;
        if (pop) begin
            cmd_reg <= q_cmd;
            cnt_reg <= q_count;
        end
    end

    // Reserve storage: one write port from the front end, one registered read
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            res_mem[wr_addr] <= wr.ev;
        end
        rd_reg <= res_mem[idx_reg[AW-1:0]];
    end

endmodule

### hdl/short_marker_pair_suppressor_unit.sv
// ----------------------------------------------------------------------------
// short_marker_pair_suppressor_unit
// Holds events inside a short window after a start marker and releases them, with start
// and end ids cleared when an end marker closes it, or unchanged before an event outside it.
// ----------------------------------------------------------------------------
// Items: the front end sequencer takes one item at a time; a flush reads each held
//   entry through the registered reserve read, and the next item waits until a
//   queued flush has fully drained out of the reserve.
// Reset: synchronous, active low; clears window, toggle, fill count, queue and
//   output valid. Reserve contents are not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module short_marker_pair_suppressor_unit #(
    parameter int unsigned RESERVE_DEPTH = smps_pkg::RESERVE_DEPTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input event transactions
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [191:0]                         s_tdata,  // event_id, event_date, event_length
    // Result transactions
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [191:0]                         m_tdata,  // out_id, out_date, out_length
    output logic                                 m_tlast,  // last result of the input item
    output logic [0:0]                           m_tuser,  // overflow
    // Configuration write port
    input  logic                                 cfg_we,
    input  logic [smps_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [smps_pkg::WORD_W-1:0]          cfg_wdata
);
    import smps_pkg::*;

    localparam int unsigned CW = $clog2(RESERVE_DEPTH + 1);
    localparam int unsigned AW = (RESERVE_DEPTH > 1) ? $clog2(RESERVE_DEPTH) : 1;
    localparam int unsigned QW = $bits(cmd_t) + CW;

    // Configuration registers
    word_t min_duration_reg, min_duration_next;
    word_t start_marker_reg, start_marker_next;
    word_t end_marker_reg,   end_marker_next;

    // Front end to queue to back end
    event_t        s_ev;
    event_t        m_ev;
    cmd_t          fq_cmd, bq_cmd;
    logic [CW-1:0] fq_count, bq_count;
    logic          fq_valid, fq_ready, bq_valid, bq_ready;
    logic [QW-1:0] bq_data;
    res_wr_t       res_wr;
    logic [AW-1:0] res_wr_addr;
    back_stat_t    back_stat;
    logic [CW-1:0] held_count;
    logic          flush_pending;
    logic          m_overflow;

    // Unpack the input transaction, first field in the low bits
    assign s_ev.id     = s_tdata[63:0];
    assign s_ev.date   = s_tdata[127:64];
    assign s_ev.length = s_tdata[191:128];

    assign m_tdata     = {m_ev.length, m_ev.date, m_ev.id};
    assign m_tuser[0]  = m_overflow;

    // Register writes; an index beyond the list is dropped
    always_comb begin
        min_duration_next = min_duration_reg;
        start_marker_next = start_marker_reg;
        end_marker_next   = end_marker_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_MIN_DURATION: min_duration_next = cfg_wdata;
                REG_START_MARKER: start_marker_next = cfg_wdata;
                REG_END_MARKER:   end_marker_next   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_duration_reg <= MIN_DURATION_RST;
            start_marker_reg <= START_MARKER_RST;
            end_marker_reg   <= END_MARKER_RST;
        end else begin
            min_duration_reg <= min_duration_next;
            start_marker_reg <= start_marker_next;
            end_marker_reg   <= end_marker_next;
        end
    end

    // Front end: window tracking and classification
    smps_front #(
        .RESERVE_DEPTH (RESERVE_DEPTH),
        .CW            (CW),
        .AW            (AW)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_ev          (s_ev),
        .min_duration  (min_duration_reg),
        .start_marker  (start_marker_reg),
        .end_marker    (end_marker_reg),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_cmd         (fq_cmd),
        .q_count       (fq_count),
        .wr            (res_wr),
        .wr_addr       (res_wr_addr),
        .back_stat     (back_stat),
        .held_count    (held_count),
        .flush_pending (flush_pending)
    );

    // Command queue decouples classification from result delivery
    smps_queue #(
        .WIDTH     (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   ({fq_count, fq_cmd}),
        .out_valid (bq_valid),
        .out_ready (bq_ready),
        .out_data  (bq_data)
    );

    assign bq_cmd   = bq_data[$bits(cmd_t)-1:0];
    assign bq_count = bq_data[QW-1:$bits(cmd_t)];

    // Back end: reserve and result stage
    smps_back #(
        .RESERVE_DEPTH (RESERVE_DEPTH),
        .CW            (CW),
        .AW            (AW)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (bq_valid),
        .q_ready       (bq_ready),
        .q_cmd         (bq_cmd),
        .q_count       (bq_count),
        .wr            (res_wr),
        .wr_addr       (res_wr_addr),
        .start_marker  (start_marker_reg),
        .end_marker    (end_marker_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_ev          (m_ev),
        .m_tlast       (m_tlast),
        .m_overflow    (m_overflow),
        .back_stat     (back_stat)
    );

    // The fill count never runs past the reserve depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count <= CW'(RESERVE_DEPTH))
        else $error("reserve fill count above depth");

    // One item at a time: an accepted transaction drops ready on the next cycle
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted on consecutive cycles");

    // A queued flush always follows a cleared fill count
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(flush_pending) |-> (held_count == '0))
        else $error("flush queued while reserve still counted as filled");

endmodule
